/* sv/olist_pkg.sv */
`timescale 1ns / 1ps
package olist_pkg;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_FIND   = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BADPOS  = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_MISSING = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic [4:0]         position;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] found_index;
		logic [4:0] entry_count;
	} result_t;

	// per-cell update command
	typedef struct packed {
		logic load;
		logic shift_up;
		logic shift_down;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

/* sv/ordered_list_insert_remove_find.sv */
`timescale 1ns / 1ps
// Ordered list of DEPTH signed 32-bit entries held in a row of cells, each
// cell storing one entry next to its neighbors. A transaction is insert at a
// position, remove the last entry equal to a value, or find the last entry
// equal to a value; each yields one result with status, index and count.
// In the cycle a transaction is accepted all cells compare their entry with
// the value in parallel and register a match bit; in the execute state, once
// the result register is free or being taken, the last match is encoded, the
// cells shift one place up or down, and the result is registered. A new
// transaction is accepted only after the last one has finished; the result
// register lets the next one enter while an earlier result is still stalled.
// Entries are undefined until written and only entries below the count are ever reported.
module ordered_list_insert_remove_find import olist_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int W  = (CW > 5) ? CW : 5;
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	state_t        state_q, state_next;
	logic [CW-1:0] count_q, count_next;
	item_t         item_q;
	result_t       result_q, result_next;
	logic          result_valid_q;
	logic          accept, finish;

	logic [31:0]    cell_data [DEPTH];
	logic [DEPTH-1:0] cell_match;
	logic [DEPTH-1:0] hit;
	logic           hit_any;
	logic [IW-1:0]  last_idx;
	logic [W-1:0]   pos_ext, cnt_ext;
	logic           ins_ok, rem_ok;
	cell_ctl_t      ctl [DEPTH];

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);

	// hold the transaction for the execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	// state and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			count_q <= count_next;
			if (finish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until it is taken
	always_ff @(posedge clk) begin
		if (finish) begin
			result_q <= result_next;
		end
	end

	// occupied cells that matched, and the last of them
	always_comb begin
		hit_any  = 1'b0;
		last_idx = '0;
		for (int k = 0; k < DEPTH; k++) begin
			hit[k] = cell_match[k] && (CW'(k) < count_q);
			if (hit[k]) begin
				hit_any  = 1'b1;
				last_idx = IW'(k);
			end
		end
	end

	assign pos_ext = W'(item_q.position);
	assign cnt_ext = W'(count_q);

	// next state, count and result
	always_comb begin
		state_next  = state_q;
		count_next  = count_q;
		finish      = 1'b0;
		ins_ok      = 1'b0;
		rem_ok      = 1'b0;
		result_next = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!result_valid_q || !result_stall) begin
					finish     = 1'b1;
					state_next = ST_IDLE;
					case (item_q.op)
						OP_INSERT: begin
							if (pos_ext > cnt_ext) begin
								result_next.status = STAT_BADPOS;
							end else if (count_q == FULL_COUNT) begin
								result_next.status = STAT_FULL;
							end else begin
								ins_ok     = 1'b1;
								count_next = count_q + CW'(1);
							end
						end
						OP_REMOVE: begin
							if (hit_any) begin
								rem_ok                  = 1'b1;
								count_next              = count_q - CW'(1);
								result_next.found_index = 4'(last_idx);
							end else begin
								result_next.status = STAT_MISSING;
							end
						end
						OP_FIND: begin
							if (hit_any) begin
								result_next.found_index = 4'(last_idx);
							end else begin
								result_next.status = STAT_MISSING;
							end
						end
						default: begin
						end
					endcase
					result_next.entry_count = 5'(count_next);
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// row of cells with per-cell shift commands
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [W-1:0] CI = W'(i);
		logic [31:0] prev_d, next_d;

		if (i == 0) begin : g_first
			assign prev_d = '0;
		end else begin : g_prev
			assign prev_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_next
			assign next_d = cell_data[i+1];
		end

		assign ctl[i].load       = ins_ok && (CI == pos_ext);
		assign ctl[i].shift_up   = ins_ok && (CI > pos_ext) && (CI <= cnt_ext);
		assign ctl[i].shift_down = rem_ok && (CI >= W'(last_idx))
			&& ((CI + W'(1)) < cnt_ext);

		olist_cell u_cell (
			.clk       (clk),
			.capture   (accept),
			.key       (item.value),
			.ctl       (ctl[i]),
			.wr_value  (item_q.value),
			.prev_data (prev_d),
			.next_data (next_d),
			.data      (cell_data[i]),
			.match     (cell_match[i])
		);
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* sv/olist_cell.sv */
`timescale 1ns / 1ps
module olist_cell import olist_pkg::*; (
	input  logic        clk,
	input  logic        capture,
	input  logic [31:0] key,
	input  cell_ctl_t   ctl,
	input  logic [31:0] wr_value,
	input  logic [31:0] prev_data,
	input  logic [31:0] next_data,
	output logic [31:0] data,
	output logic        match
);

	logic [31:0] data_q;
	logic        match_q;

	// compare the stored entry against the key of a new transaction
	always_ff @(posedge clk) begin
		if (capture) begin
			match_q <= (data_q == key);
		end
	end

	// load, or take the neighbor's entry when the list moves
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= wr_value;
		end else if (ctl.shift_up) begin
			data_q <= prev_data;
		end else if (ctl.shift_down) begin
			data_q <= next_data;
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

/* test/ordered_list_insert_remove_find_test.sv */
`timescale 1ns / 1ps
module ordered_list_insert_remove_find_test;
	import olist_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 200;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Expected list contents and the results still owed by the block
	class list_scoreboard;
		logic [31:0] cells[LIST_DEPTH];
		int unsigned held;
		result_t expected_results[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned op_seen[4];
		int unsigned status_seen[4];

		function new();
			held = 0;
			mismatches = 0;
			checked = 0;
			foreach (op_seen[i]) op_seen[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		// Return the last index holding v, or -1 when absent
		function int last_match(logic [31:0] v);
			int hit;
			hit = -1;
			for (int i = 0; i < held; i++)
				if (cells[i] == v) hit = i;
			return hit;
		endfunction

		// Apply an accepted transaction to the list and queue its result
		function void note_transaction(item_t it);
			result_t want;
			int hit;
			want = '0;
			op_seen[it.op]++;
			case (it.op)
				OP_INSERT: begin
					if (it.position > held) begin
						want.status = STAT_BADPOS;
					end else if (held >= LIST_DEPTH) begin
						want.status = STAT_FULL;
					end else begin
						for (int i = held; i > it.position; i--)
							cells[i] = cells[i - 1];
						cells[it.position] = it.value;
						held++;
						want.status = STAT_OK;
					end
				end
				OP_REMOVE: begin
					hit = last_match(it.value);
					if (hit < 0) begin
						want.status = STAT_MISSING;
					end else begin
						for (int i = hit; i + 1 < held; i++)
							cells[i] = cells[i + 1];
						held--;
						want.status = STAT_OK;
						want.found_index = hit[3:0];
					end
				end
				OP_FIND: begin
					hit = last_match(it.value);
					if (hit < 0) begin
						want.status = STAT_MISSING;
					end else begin
						want.status = STAT_OK;
						want.found_index = hit[3:0];
					end
				end
				default: want.status = STAT_OK;
			endcase
			want.entry_count = held[4:0];
			status_seen[want.status]++;
			expected_results.push_back(want);
		endfunction

		// Compare a delivered result with the oldest expectation
		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result status=%0d index=%0d count=%0d",
						got.status, got.found_index, got.entry_count);
				return;
			end
			want = expected_results.pop_front();
			checked++;
			if (got.status !== want.status || got.found_index !== want.found_index ||
					got.entry_count !== want.entry_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"ERROR: result %0d expected status=%0d index=%0d count=%0d,",
						" got status=%0d index=%0d count=%0d"},
						checked, want.status, want.found_index, want.entry_count,
						got.status, got.found_index, got.entry_count);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;

	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned quiet_cycles;
	list_scoreboard sb;

	logic [31:0] value_pool[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
		32'hffff_ffff, 32'h0000_0001, 32'h1234_5678};

	ordered_list_insert_remove_find #(.DEPTH(LIST_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// Check delivered results, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic item_t make_item(logic [1:0] op, logic [4:0] pos, logic [31:0] val);
		item_t it;
		it.op = op;
		it.position = pos;
		it.value = val;
		return it;
	endfunction

	// Build a random transaction; mode 0 fills the list, 1 drains it, 2 mixes
	function automatic item_t random_item(int mode);
		item_t it;
		int unsigned roll;
		int unsigned pick;
		roll = $urandom_range(99);
		pick = $urandom_range(99);
		case (mode)
			0: it.op = roll < 85 ? OP_INSERT : roll < 92 ? OP_FIND : roll < 97 ? OP_REMOVE
				: OP_UNUSED;
			1: it.op = roll < 65 ? OP_REMOVE : roll < 85 ? OP_FIND : roll < 97 ? OP_INSERT
				: OP_UNUSED;
			default: it.op = roll < 40 ? OP_INSERT : roll < 65 ? OP_REMOVE : roll < 95 ? OP_FIND
				: OP_UNUSED;
		endcase
		if (it.op != OP_INSERT || $urandom_range(9) == 0)
			it.position = 5'($urandom_range(31));
		else
			it.position = 5'($urandom_range(sb.held));
		// favor values already held so removes and finds hit
		if (it.op != OP_INSERT && sb.held > 0 && pick < 50)
			it.value = sb.cells[$urandom_range(sb.held - 1)];
		else if (pick < 80)
			it.value = value_pool[$urandom_range(5)];
		else
			it.value = $urandom;
		return it;
	endfunction

	// Offer one transaction, idling first at random, and hold it until taken
	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.note_transaction(it);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, extremes, duplicates, bad positions, misses
		send_item(make_item(OP_FIND, 5'd0, 32'd5));
		send_item(make_item(OP_REMOVE, 5'd0, 32'd5));
		send_item(make_item(OP_INSERT, 5'd1, 32'd7));
		send_item(make_item(OP_INSERT, 5'd0, 32'h7fff_ffff));
		send_item(make_item(OP_INSERT, 5'd0, 32'h8000_0000));
		send_item(make_item(OP_INSERT, 5'd2, 32'h0000_0000));
		send_item(make_item(OP_INSERT, 5'd1, 32'hffff_ffff));
		send_item(make_item(OP_INSERT, 5'd31, 32'd5));
		send_item(make_item(OP_INSERT, 5'd4, 32'h7fff_ffff));
		send_item(make_item(OP_FIND, 5'd0, 32'h7fff_ffff));
		send_item(make_item(OP_FIND, 5'd31, 32'h8000_0000));
		send_item(make_item(OP_FIND, 5'd0, 32'd12345));
		send_item(make_item(OP_UNUSED, 5'd31, 32'hffff_ffff));
		send_item(make_item(OP_REMOVE, 5'd0, 32'h7fff_ffff));
		send_item(make_item(OP_FIND, 5'd0, 32'h7fff_ffff));
		send_item(make_item(OP_REMOVE, 5'd0, 32'h8000_0000));
		send_item(make_item(OP_INSERT, 5'd0, 32'h5555_5555));
		send_item(make_item(OP_INSERT, 5'd3, 32'haaaa_aaaa));
		send_item(make_item(OP_REMOVE, 5'd0, 32'd12345));
		send_item(make_item(OP_INSERT, 5'd16, 32'd9));
		send_item(make_item(OP_FIND, 5'd0, 32'haaaa_aaaa));

		// Random phases with different idle and stall rates
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 55; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 55; end
				default: begin send_idle_pct = 27; stall_pct = 27; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2) wait_drained();
				send_item(random_item((n / 24) % 3));
			end
		end

		// Drain and let the pipeline settle
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Ran %0d inserts, %0d removes, %0d finds and %0d unused op codes",
			sb.op_seen[OP_INSERT], sb.op_seen[OP_REMOVE], sb.op_seen[OP_FIND],
			sb.op_seen[OP_UNUSED]);
		$display("Outcomes: ok %0d, bad position %0d, full %0d, not found %0d; %0d errors",
			sb.status_seen[STAT_OK], sb.status_seen[STAT_BADPOS], sb.status_seen[STAT_FULL],
			sb.status_seen[STAT_MISSING], sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
